### src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants for the rgb/hsv colour converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    // direction codes
    localparam logic FUNC_RGB2HSV = 1'b0;
    localparam logic FUNC_HSV2RGB = 1'b1;

    // widths of the divider pipeline
    localparam int DIV_NW = 22;
    localparam int DIV_DW = 14;

    localparam logic [DIV_DW-1:0] DEN_SF = 14'd15300;

    // reciprocals for the constant divisions: x/255 for 16-bit x, x/15300 for 22-bit x
    localparam logic [16:0] RCP_P     = 17'd65794;
    localparam int          RCP_P_SH  = 24;
    localparam logic [22:0] RCP_SF    = 23'd4491470;
    localparam int          RCP_SF_SH = 36;

    localparam logic [9:0] HUE_ACHROM = 10'h3FF;

    // which component holds the maximum
    typedef enum logic [1:0] {
        MSEL_RED,
        MSEL_GREEN,
        MSEL_BLUE
    } msel_t;

    // per-word control carried alongside the dividers
    typedef struct packed {
        logic       func;
        logic       achrom;
        msel_t      msel;
        logic       neg;
        logic [7:0] mx;
        logic [7:0] v;
        logic [2:0] sec;
    } side_t;

endpackage

### src/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// restoring divider, one quotient bit per register stage, no stall
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int NW = 22,
    parameter int DW = 14
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0] num_prev;
        logic [NW-1:0] quo_prev;
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign num_prev = num;
            assign quo_prev = '0;
            assign rem_prev = '0;
            assign den_prev = den;
        end
        else begin : g_rest
            assign num_prev = num_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        assign trial    = {rem_prev, num_prev[NW-1-k]};
        assign ge       = (trial >= {1'b0, den_prev});
        assign rem_next = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
        assign quo_next = {quo_prev[NW-2:0], ge};

        always_ff @(posedge clk)
        begin
            num_reg[k] <= num_prev;
            quo_reg[k] <= quo_next;
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_prev;
        end
    end

    assign quo = quo_reg[NW-1];
    assign rem = rem_reg[NW-1];

endmodule

### src/rgb_hsv_color_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_core
// pipelined rgb <-> hsv converter, one word per clock
// ----------------------------------------------------------------------------
// A word is taken whenever start is high; busy is always low. Each word gives
// one result, shown for a single cycle with done high, after it passes three
// stages of compare and multiply, a 22-stage bit-per-cycle divider and the
// output register. Results leave in order and the receiver cannot stall them.
module rgb_hsv_color_converter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic [8:0]         hue_in,
    input  logic signed [10:0] sat_in,
    input  logic signed [10:0] val_in,
    output logic               done,
    output logic signed [9:0]  hue_out,
    output logic [7:0]         sat_out,
    output logic [7:0]         val_out,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out
);

    localparam int NW = rhc_pkg::DIV_NW;
    localparam int DW = rhc_pkg::DIV_DW;

    // ---------------- stage 1: max/min, clamps, sector
    logic [7:0]          mx, mn, dl, mag, s_cl, v_cl;
    logic signed [8:0]   diff;
    rhc_pkg::msel_t      msel;
    logic [3:0]          sec_raw;
    logic [8:0]          fr_full;

    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        dl = mx - mn;
        if (red_in == mx)
        begin
            msel = rhc_pkg::MSEL_RED;
            diff = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
        end
        else if (green_in == mx)
        begin
            msel = rhc_pkg::MSEL_GREEN;
            diff = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
        end
        else
        begin
            msel = rhc_pkg::MSEL_BLUE;
            diff = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        end
        mag = diff[8] ? 8'(-diff) : diff[7:0];
    end

    always_comb
    begin
        if (sat_in[10])            s_cl = 8'd0;
        else if (sat_in > 11'sd255) s_cl = 8'd255;
        else                       s_cl = sat_in[7:0];
        if (val_in[10])            v_cl = 8'd0;
        else if (val_in > 11'sd255) v_cl = 8'd255;
        else                       v_cl = val_in[7:0];
    end

    always_comb
    begin
        if (hue_in >= 9'd480)      sec_raw = 4'd8;
        else if (hue_in >= 9'd420) sec_raw = 4'd7;
        else if (hue_in >= 9'd360) sec_raw = 4'd6;
        else if (hue_in >= 9'd300) sec_raw = 4'd5;
        else if (hue_in >= 9'd240) sec_raw = 4'd4;
        else if (hue_in >= 9'd180) sec_raw = 4'd3;
        else if (hue_in >= 9'd120) sec_raw = 4'd2;
        else if (hue_in >= 9'd60)  sec_raw = 4'd1;
        else                       sec_raw = 4'd0;
        fr_full = hue_in - 9'(9'(sec_raw) * 9'd60);
    end

    logic                v1_reg;
    rhc_pkg::side_t      sd1_reg;
    logic [7:0]          dl1_reg, mag1_reg, s1_reg;
    logic [5:0]          fr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        sd1_reg.func   <= func;
        sd1_reg.achrom <= (dl == 8'd0);
        sd1_reg.msel   <= msel;
        sd1_reg.neg    <= diff[8];
        sd1_reg.mx     <= mx;
        sd1_reg.v      <= v_cl;
        sd1_reg.sec    <= (sec_raw > 4'd5) ? 3'd5 : sec_raw[2:0];
        dl1_reg        <= dl;
        mag1_reg       <= mag;
        s1_reg         <= s_cl;
        fr1_reg        <= fr_full[5:0];
    end

    // ---------------- stage 2: first products
    logic                v2_reg;
    rhc_pkg::side_t      sd2_reg;
    logic [7:0]          dl2_reg;
    logic [15:0]         nsat2_reg, np2_reg;
    logic [13:0]         nhue2_reg, sfr2_reg, s602_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        sd2_reg   <= sd1_reg;
        dl2_reg   <= dl1_reg;
        nsat2_reg <= 16'(16'(dl1_reg) * 16'd255);
        nhue2_reg <= 14'(14'(mag1_reg) * 14'd60);
        np2_reg   <= 16'(16'(sd1_reg.v) * 16'(8'd255 - s1_reg));
        sfr2_reg  <= 14'(14'(s1_reg) * 14'(fr1_reg));
        s602_reg  <= 14'(14'(s1_reg) * 14'(6'd60 - fr1_reg));
    end

    // ---------------- stage 3: second products for q and t
    logic                v3_reg;
    rhc_pkg::side_t      sd3_reg;
    logic [7:0]          dl3_reg;
    logic [15:0]         nsat3_reg, np3_reg;
    logic [13:0]         nhue3_reg;
    logic [21:0]         nq3_reg, nt3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        sd3_reg   <= sd2_reg;
        dl3_reg   <= dl2_reg;
        nsat3_reg <= nsat2_reg;
        nhue3_reg <= nhue2_reg;
        np3_reg   <= np2_reg;
        nq3_reg   <= 22'(22'(sd2_reg.v) * 22'(rhc_pkg::DEN_SF - sfr2_reg));
        nt3_reg   <= 22'(22'(sd2_reg.v) * 22'(rhc_pkg::DEN_SF - s602_reg));
    end

    // ---------------- dividers
    logic [NW-1:0] sat_q, hue_q;
    logic [DW-1:0] sat_r, hue_r;
    logic [DW-1:0] dl_den, mx_den;

    assign dl_den = DW'(dl3_reg);
    assign mx_den = DW'(sd3_reg.mx);

    rhc_div #(.NW(NW), .DW(DW)) u_div_sat (
        .clk (clk),
        .num (NW'(nsat3_reg)),
        .den (mx_den),
        .quo (sat_q),
        .rem (sat_r)
    );

    rhc_div #(.NW(NW), .DW(DW)) u_div_hue (
        .clk (clk),
        .num (NW'(nhue3_reg)),
        .den (dl_den),
        .quo (hue_q),
        .rem (hue_r)
    );

    // p, q and t divide by constants: reciprocal multiply, then ride along
    logic [31:0] pm;
    logic [43:0] qm, tm;

    assign pm = 32'(32'(np3_reg) * 32'(rhc_pkg::RCP_P));
    assign qm = 44'(44'(nq3_reg) * 44'(rhc_pkg::RCP_SF));
    assign tm = 44'(44'(nt3_reg) * 44'(rhc_pkg::RCP_SF));

    // control travelling in step with the dividers
    logic           vd_reg [NW];
    rhc_pkg::side_t sdd_reg [NW];
    logic [7:0]     pd_reg [NW];
    logic [7:0]     qd_reg [NW];
    logic [7:0]     td_reg [NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
                vd_reg[i] <= 1'b0;
        end
        else
        begin
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < NW; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sdd_reg[0] <= sd3_reg;
        pd_reg[0]  <= pm[rhc_pkg::RCP_P_SH +: 8];
        qd_reg[0]  <= qm[rhc_pkg::RCP_SF_SH +: 8];
        td_reg[0]  <= tm[rhc_pkg::RCP_SF_SH +: 8];
        for (int i = 1; i < NW; i++)
        begin
            sdd_reg[i] <= sdd_reg[i-1];
            pd_reg[i]  <= pd_reg[i-1];
            qd_reg[i]  <= qd_reg[i-1];
            td_reg[i]  <= td_reg[i-1];
        end
    end

    // ---------------- output assembly
    rhc_pkg::side_t sdo;
    logic [9:0]     hq, hue_next;
    logic           rnz;
    logic [7:0]     pv, qv, tv;
    logic [7:0]     sat_next, val_next, red_next, green_next, blue_next;

    assign sdo = sdd_reg[NW-1];
    assign hq  = 10'(hue_q[5:0]);
    assign rnz = (hue_r != '0);
    assign pv  = pd_reg[NW-1];
    assign qv  = qd_reg[NW-1];
    assign tv  = td_reg[NW-1];

    always_comb
    begin
        hue_next   = '0;
        sat_next   = '0;
        val_next   = '0;
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (sdo.func == rhc_pkg::FUNC_RGB2HSV)
        begin
            val_next = sdo.mx;
            if (sdo.achrom)
                hue_next = rhc_pkg::HUE_ACHROM;
            else
            begin
                sat_next = sat_q[7:0];
                case (sdo.msel)
                    rhc_pkg::MSEL_RED:
                        hue_next = (sdo.neg && hq != 10'd0) ? 10'd360 - hq : hq;
                    rhc_pkg::MSEL_GREEN:
                        hue_next = sdo.neg ? 10'd120 - hq - 10'(rnz) : 10'd120 + hq;
                    default:
                        hue_next = sdo.neg ? 10'd240 - hq - 10'(rnz) : 10'd240 + hq;
                endcase
            end
        end
        else
        begin
            // sectors six to eight fold onto five
            case (sdo.sec)
                3'd0:
                begin
                    red_next = sdo.v; green_next = tv;    blue_next = pv;
                end
                3'd1:
                begin
                    red_next = qv;    green_next = sdo.v; blue_next = pv;
                end
                3'd2:
                begin
                    red_next = pv;    green_next = sdo.v; blue_next = tv;
                end
                3'd3:
                begin
                    red_next = pv;    green_next = qv;    blue_next = sdo.v;
                end
                3'd4:
                begin
                    red_next = tv;    green_next = pv;    blue_next = sdo.v;
                end
                default:
                begin
                    red_next = sdo.v; green_next = pv;    blue_next = qv;
                end
            endcase
        end
    end

    logic       done_reg;
    logic [9:0] hue_reg;
    logic [7:0] sat_reg, val_reg, red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vd_reg[NW-1];
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= sat_next;
        val_reg   <= val_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign hue_out   = $signed(hue_reg);
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

### bench/rgb_hsv_color_converter_core_tb.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_core_tb
// checks both conversion directions against an integer colour predictor
// ----------------------------------------------------------------------------
// Words are queued by an initial block and driven with random gaps. Each word
// is predicted when it is taken, and every result marked by done is compared
// with the oldest prediction.
module rgb_hsv_color_converter_core_tb;

    typedef struct {
        logic              fn;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [8:0]        h;
        logic signed [10:0] s;
        logic signed [10:0] v;
    } pixel_t;

    typedef struct {
        logic signed [9:0] hue;
        logic [7:0]        sat;
        logic [7:0]        val;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
    } colour_t;

    localparam int LATENCY = 26;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [8:0]         hue_in;
    logic signed [10:0] sat_in;
    logic signed [10:0] val_in;
    logic               done;
    logic signed [9:0]  hue_out;
    logic [7:0]         sat_out;
    logic [7:0]         val_out;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;

    pixel_t  pixel_q[$];
    colour_t colour_q[$];
    int      fail_cnt;
    int      gap_left;
    int      cycle_cnt;
    bit      hold_for_drain;

    rgb_hsv_color_converter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .hue_in    (hue_in),
        .sat_in    (sat_in),
        .val_in    (val_in),
        .done      (done),
        .hue_out   (hue_out),
        .sat_out   (sat_out),
        .val_out   (val_out),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int clamp_byte(int x);
        if (x < 0)
            return 0;
        if (x > 255)
            return 255;
        return x;
    endfunction

    function automatic colour_t convert_pixel(pixel_t px);
        colour_t c;
        int r, g, b, mx, mn, dl, hh;
        int h, s, v, sec, fr, p, q, t;
        c = '{default: '0};
        if (px.fn == rhc_pkg::FUNC_RGB2HSV)
        begin
            r = px.r;
            g = px.g;
            b = px.b;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            dl = mx - mn;
            c.val = mx[7:0];
            if (mx == 0 || dl == 0)
            begin
                c.hue = rhc_pkg::HUE_ACHROM;
                return c;
            end
            c.sat = 8'((255 * dl) / mx);
            if (r == mx)
                hh = (60 * (g - b)) / dl;
            else if (g == mx)
                hh = (120 * dl + 60 * (b - r)) / dl;
            else
                hh = (240 * dl + 60 * (r - g)) / dl;
            if (hh < 0)
                hh += 360;
            c.hue = 10'(hh);
        end
        else
        begin
            h = px.h;
            s = clamp_byte(px.s);
            v = clamp_byte(px.v);
            if (s == 0)
            begin
                c.r = v[7:0];
                c.g = v[7:0];
                c.b = v[7:0];
                return c;
            end
            sec = h / 60;
            fr = h - 60 * sec;
            p = (v * (255 - s)) / 255;
            q = (v * (15300 - s * fr)) / 15300;
            t = (v * (15300 - s * (60 - fr))) / 15300;
            case (sec)
                0: begin c.r = v[7:0]; c.g = t[7:0]; c.b = p[7:0]; end
                1: begin c.r = q[7:0]; c.g = v[7:0]; c.b = p[7:0]; end
                2: begin c.r = p[7:0]; c.g = v[7:0]; c.b = t[7:0]; end
                3: begin c.r = p[7:0]; c.g = q[7:0]; c.b = v[7:0]; end
                4: begin c.r = t[7:0]; c.g = p[7:0]; c.b = v[7:0]; end
                default: begin c.r = v[7:0]; c.g = p[7:0]; c.b = q[7:0]; end
            endcase
        end
        return c;
    endfunction

    function automatic pixel_t rgb_word(int r, int g, int b);
        pixel_t px;
        px.fn = rhc_pkg::FUNC_RGB2HSV;
        px.r = 8'(r);
        px.g = 8'(g);
        px.b = 8'(b);
        px.h = 9'($urandom_range(511));
        px.s = 11'($urandom);
        px.v = 11'($urandom);
        return px;
    endfunction

    function automatic pixel_t hsv_word(int h, int s, int v);
        pixel_t px;
        px.fn = rhc_pkg::FUNC_HSV2RGB;
        px.r = 8'($urandom);
        px.g = 8'($urandom);
        px.b = 8'($urandom);
        px.h = 9'(h);
        px.s = 11'(s);
        px.v = 11'(v);
        return px;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        int wait_now;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (start && busy)
            start <= 1'b1;
        else
        begin
            wait_now = gap_left;
            if (start)
            begin
                colour_q.push_back(convert_pixel(pixel_q.pop_front()));
                wait_now = $urandom_range(3) == 0 ? 0 : $urandom_range(14);
            end
            if (wait_now == 0 && pixel_q.size() > 0 && !hold_for_drain)
            begin
                // word stays on the ports until taken
                start <= 1'b1;
                gap_left <= 0;
                func <= pixel_q[0].fn;
                red_in <= pixel_q[0].r;
                green_in <= pixel_q[0].g;
                blue_in <= pixel_q[0].b;
                hue_in <= pixel_q[0].h;
                sat_in <= pixel_q[0].s;
                val_in <= pixel_q[0].v;
            end
            else
            begin
                start <= 1'b0;
                gap_left <= (wait_now > 0) ? wait_now - 1 : 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        colour_t e;
        if (rst_n && done)
        begin
            if (colour_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, hue %0d", $time, hue_out);
                fail_cnt++;
            end
            else
            begin
                e = colour_q.pop_front();
                if (hue_out !== e.hue)
                begin
                    $display("%0t: hue_out exp %0d got %0d", $time, e.hue, hue_out);
                    fail_cnt++;
                end
                if (sat_out !== e.sat)
                begin
                    $display("%0t: sat_out exp %0d got %0d", $time, e.sat, sat_out);
                    fail_cnt++;
                end
                if (val_out !== e.val)
                begin
                    $display("%0t: val_out exp %0d got %0d", $time, e.val, val_out);
                    fail_cnt++;
                end
                if (red_out !== e.r)
                begin
                    $display("%0t: red_out exp %0d got %0d", $time, e.r, red_out);
                    fail_cnt++;
                end
                if (green_out !== e.g)
                begin
                    $display("%0t: green_out exp %0d got %0d", $time, e.g, green_out);
                    fail_cnt++;
                end
                if (blue_out !== e.b)
                begin
                    $display("%0t: blue_out exp %0d got %0d", $time, e.b, blue_out);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int k, sel;
        fail_cnt = 0;
        cycle_cnt = 0;
        hold_for_drain = 0;
        start = 1'b0;
        func = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        hue_in = '0;
        sat_in = '0;
        val_in = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, greys, each hue sector, clamping, hue past 359
        pixel_q.push_back(rgb_word(0, 0, 0));
        pixel_q.push_back(rgb_word(255, 255, 255));
        pixel_q.push_back(rgb_word(128, 128, 128));
        pixel_q.push_back(rgb_word(255, 0, 0));
        pixel_q.push_back(rgb_word(0, 255, 0));
        pixel_q.push_back(rgb_word(0, 0, 255));
        pixel_q.push_back(rgb_word(255, 0, 1));
        pixel_q.push_back(rgb_word(1, 0, 0));
        pixel_q.push_back(rgb_word(255, 255, 0));
        pixel_q.push_back(rgb_word(255, 0, 255));
        pixel_q.push_back(hsv_word(0, 255, 255));
        pixel_q.push_back(hsv_word(359, 255, 255));
        pixel_q.push_back(hsv_word(511, 1023, 1023));
        pixel_q.push_back(hsv_word(400, 200, 200));
        pixel_q.push_back(hsv_word(100, 0, 77));
        pixel_q.push_back(hsv_word(200, -1024, -1024));
        pixel_q.push_back(hsv_word(60, 255, -5));
        pixel_q.push_back(hsv_word(150, 300, 300));
        pixel_q.push_back(hsv_word(210, 128, 255));
        pixel_q.push_back(hsv_word(270, 1, 1));
        pixel_q.push_back(hsv_word(330, 255, 0));

        // wait for the directed words to drain fully
        wait (pixel_q.size() == 0 && colour_q.size() == 0);
        hold_for_drain = 1;
        repeat (LATENCY + 4) @(posedge clk);
        hold_for_drain = 0;

        for (k = 0; k < 500; k++)
        begin
            sel = $urandom_range(9);
            if (sel < 4)
                pixel_q.push_back(rgb_word($urandom_range(255), $urandom_range(255),
                                           $urandom_range(255)));
            else if (sel == 4)
            begin
                sel = $urandom_range(255);
                pixel_q.push_back(rgb_word(sel, sel, sel));
            end
            else if (sel < 8)
                pixel_q.push_back(hsv_word($urandom_range(359), $urandom_range(255),
                                           $urandom_range(255)));
            else
                pixel_q.push_back(hsv_word($urandom_range(511), $urandom_range(2047),
                                           $urandom_range(2047)));
        end
        wait (pixel_q.size() == 0 && colour_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
